>>> rtl/ypab_pkg.sv
`timescale 1ns / 1ps
// Shared types, Q8 color constants and the saturation helper for the YUV alpha blender.
// No dependencies.
package ypab_pkg;

	// JFIF YCbCr to RGB, Q8
	localparam int K_R_CR = 359;
	localparam int K_G_CB = 88;
	localparam int K_G_CR = 183;
	localparam int K_B_CB = 454;

	// RGB to YCbCr, Q8
	localparam int K_Y_R  = 77;
	localparam int K_Y_G  = 150;
	localparam int K_Y_B  = 29;
	localparam int K_CB_R = 43;
	localparam int K_CB_G = 85;
	localparam int K_CB_B = 128;
	localparam int K_CR_R = 128;
	localparam int K_CR_G = 107;
	localparam int K_CR_B = 21;

	localparam int CHROMA_OFS = 128;
	localparam logic [7:0] WEIGHT_RESET = 8'd255;

	typedef struct packed {
		logic [7:0] luma_a;
		logic [7:0] cb_a;
		logic [7:0] cr_a;
		logic [7:0] luma_b;
		logic [7:0] cb_b;
		logic [7:0] cr_b;
	} pair_t;

	typedef struct packed {
		logic [7:0] luma_out;
		logic [7:0] cb_out;
		logic [7:0] cr_out;
	} pix_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// clamp a signed value to 0..255
	function automatic logic [7:0] sat8(input logic signed [18:0] v);
		logic [7:0] res;
		if (v < 19'sd0) begin
			res = 8'd0;
		end else if (v > 19'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

>>> rtl/ypab_pair_if.sv
`timescale 1ns / 1ps
// Input channel: one pixel pair per beat, valid/ready handshake.
// Depends on ypab_pkg.
interface ypab_pair_if;
	logic             valid;
	logic             ready;
	ypab_pkg::pair_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ypab_pix_if.sv
`timescale 1ns / 1ps
// Output channel: one blended pixel per beat, valid/ready handshake.
// Depends on ypab_pkg.
interface ypab_pix_if;
	logic            valid;
	logic            ready;
	ypab_pkg::pix_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ypab_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel carrying the blend weight.
// No dependencies.
interface ypab_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ypab_yuv2rgb.sv
`timescale 1ns / 1ps
// Combinational JFIF YCbCr to RGB conversion of one pixel, Q8, saturated.
// Depends on ypab_pkg.
module ypab_yuv2rgb (
	input  logic [7:0]      luma,
	input  logic [7:0]      cb,
	input  logic [7:0]      cr,
	output ypab_pkg::rgb_t  rgb
);

	logic signed [8:0]  dcb;
	logic signed [8:0]  dcr;
	logic signed [18:0] yq;
	logic signed [18:0] r_acc;
	logic signed [18:0] g_acc;
	logic signed [18:0] b_acc;

	always_comb begin
		dcb   = $signed({1'b0, cb}) - 9'sd128;
		dcr   = $signed({1'b0, cr}) - 9'sd128;
		yq    = $signed({3'b000, luma, 8'h00});
		r_acc = yq + 19'(ypab_pkg::K_R_CR) * 19'(dcr);
		g_acc = yq - 19'(ypab_pkg::K_G_CB) * 19'(dcb) - 19'(ypab_pkg::K_G_CR) * 19'(dcr);
		b_acc = yq + 19'(ypab_pkg::K_B_CB) * 19'(dcb);
		// arithmetic shift is a floor shift
		rgb.r = ypab_pkg::sat8(r_acc >>> 8);
		rgb.g = ypab_pkg::sat8(g_acc >>> 8);
		rgb.b = ypab_pkg::sat8(b_acc >>> 8);
	end

endmodule

>>> rtl/yuv_pixel_alpha_blend.sv
`timescale 1ns / 1ps
// Alpha blend of two YCbCr pixels through RGB. Three register stages:
// s1 YCbCr to RGB of both pixels, s2 weighted mix, s3 RGB to YCbCr (output register).
// A pixel pair passes the s1, s2 and s3 registers in order before its result is valid at the output;
// throughput one pixel pair per cycle while the output is not stalled.
// A stalled output backs up the stages only as far as they are full; bubbles are absorbed.
// arst_n clears all valid bits and sets blend weight to 255.
// Depends on ypab_pkg, ypab_pair_if, ypab_pix_if, ypab_cfg_if, ypab_yuv2rgb.
module yuv_pixel_alpha_blend (
	input  logic        clk,
	input  logic        arst_n,
	ypab_pair_if.sink   pix_in,
	ypab_pix_if.source  pix_out,
	ypab_cfg_if.sink    cfg
);

	logic [7:0]      blend_weight_q;

	logic            v_s1, v_s2, v_s3;
	logic            adv1, adv2, adv3;
	ypab_pkg::rgb_t  rgb_a, rgb_b;
	ypab_pkg::rgb_t  rgb_a_s1, rgb_b_s1;
	ypab_pkg::rgb_t  mix, mix_s2;
	ypab_pkg::pix_t  yuv, yuv_s3;

	logic [8:0]      wa, wb;

	logic signed [17:0] rs, gs, bs;
	logic signed [17:0] y_acc, cb_acc, cr_acc;

	function automatic logic [7:0] mix_ch(input logic [7:0] ca, input logic [7:0] cb_v,
			input logic [8:0] wa_v, input logic [8:0] wb_v);
		logic [15:0] sum;
		sum = 16'(ca) * 16'(wa_v) + 16'(cb_v) * 16'(wb_v);
		return sum[15:8];
	endfunction

	// config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_weight_q <= ypab_pkg::WEIGHT_RESET;
		end else if (cfg.valid) begin
			blend_weight_q <= cfg.data;
		end
	end

	// stage advance: a stage loads when it is empty or its content moves on
	assign adv3         = !v_s3 || pix_out.ready;
	assign adv2         = !v_s2 || adv3;
	assign adv1         = !v_s1 || adv2;
	assign pix_in.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pix_in.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// s1: color space to RGB
	ypab_yuv2rgb u_rgb_a (
		.luma (pix_in.data.luma_a),
		.cb   (pix_in.data.cb_a),
		.cr   (pix_in.data.cr_a),
		.rgb  (rgb_a)
	);

	ypab_yuv2rgb u_rgb_b (
		.luma (pix_in.data.luma_b),
		.cb   (pix_in.data.cb_b),
		.cr   (pix_in.data.cr_b),
		.rgb  (rgb_b)
	);

	always_ff @(posedge clk) begin
		if (adv1) begin
			rgb_a_s1 <= rgb_a;
			rgb_b_s1 <= rgb_b;
		end
	end

	// s2: weighted mix, always within 0..255
	always_comb begin
		wa    = {1'b0, blend_weight_q};
		wb    = 9'd256 - wa;
		mix.r = mix_ch(rgb_a_s1.r, rgb_b_s1.r, wa, wb);
		mix.g = mix_ch(rgb_a_s1.g, rgb_b_s1.g, wa, wb);
		mix.b = mix_ch(rgb_a_s1.b, rgb_b_s1.b, wa, wb);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mix_s2 <= mix;
		end
	end

	// s3: back to YCbCr
	always_comb begin
		rs     = $signed({10'd0, mix_s2.r});
		gs     = $signed({10'd0, mix_s2.g});
		bs     = $signed({10'd0, mix_s2.b});
		y_acc  = 18'(ypab_pkg::K_Y_R) * rs + 18'(ypab_pkg::K_Y_G) * gs
			+ 18'(ypab_pkg::K_Y_B) * bs;
		cb_acc = 18'(ypab_pkg::K_CB_B) * bs - 18'(ypab_pkg::K_CB_R) * rs
			- 18'(ypab_pkg::K_CB_G) * gs;
		cr_acc = 18'(ypab_pkg::K_CR_R) * rs - 18'(ypab_pkg::K_CR_G) * gs
			- 18'(ypab_pkg::K_CR_B) * bs;
		yuv.luma_out = ypab_pkg::sat8(19'(y_acc >>> 8));
		yuv.cb_out   = ypab_pkg::sat8(19'(cb_acc >>> 8) + 19'(ypab_pkg::CHROMA_OFS));
		yuv.cr_out   = ypab_pkg::sat8(19'(cr_acc >>> 8) + 19'(ypab_pkg::CHROMA_OFS));
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			yuv_s3 <= yuv;
		end
	end

	assign pix_out.valid = v_s3;
	assign pix_out.data  = yuv_s3;

endmodule

>>> rtl/ypab_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the YUV alpha blender, bound to the top level.
// Depends on ypab_pkg and yuv_pixel_alpha_blend.
module ypab_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input ypab_pkg::pix_t  out_data
);

	// a beat waiting at the output holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat dropped or changed under stall");

	// input back-pressure only comes from a stalled full output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// empty output means the pipe can still take a beat
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output is empty");

	// a free-running pipe with no new beats runs empty while the output stays ready
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready)
			##1 !(in_valid && in_ready) && out_ready
			##1 !(in_valid && in_ready) && out_ready |=> !out_valid)
		else $error("output beat without matching input");

endmodule

bind yuv_pixel_alpha_blend ypab_checker u_ypab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  (pix_out.data)
);

>>> tb/ypab_blend_checker.sv
`timescale 1ns / 1ps
// Checker for the YCbCr alpha blender: watches the pair, pixel and weight channels,
// predicts every blended pixel and compares it with what the block delivers.
// Depends on ypab_pkg, ypab_pair_if, ypab_pix_if, ypab_cfg_if.
module ypab_blend_checker (
	input  logic clk,
	input  logic arst_n,
	ypab_pair_if pairs,
	ypab_pix_if  pixels,
	ypab_cfg_if  cfg,
	output int   fail_count,
	output int   pixels_owed
);
	import ypab_pkg::*;

	// JFIF coefficients in Q8
	localparam int CR_TO_R   = 359;
	localparam int CB_TO_G   = 88;
	localparam int CR_TO_G   = 183;
	localparam int CB_TO_B   = 454;
	localparam int Y_FROM_R  = 77;
	localparam int Y_FROM_G  = 150;
	localparam int Y_FROM_B  = 29;
	localparam int CB_FROM_R = 43;
	localparam int CB_FROM_G = 85;
	localparam int CB_FROM_B = 128;
	localparam int CR_FROM_R = 128;
	localparam int CR_FROM_G = 107;
	localparam int CR_FROM_B = 21;
	localparam int CHROMA_MID = 128;

	pix_t       owed_pixels[$];
	pix_t       want_pix;
	logic [7:0] weight = WEIGHT_RESET;

	function automatic logic [7:0] clip_byte(input int v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	// shifts below act on signed ints, so >>> floors toward minus infinity
	function automatic rgb_t ycc_to_rgb(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr);
		int   yq;
		int   dcb;
		int   dcr;
		rgb_t c;
		yq  = int'(y) * 256;
		dcb = int'(cb) - CHROMA_MID;
		dcr = int'(cr) - CHROMA_MID;
		c.r = clip_byte((yq + CR_TO_R * dcr) >>> 8);
		c.g = clip_byte((yq - CB_TO_G * dcb - CR_TO_G * dcr) >>> 8);
		c.b = clip_byte((yq + CB_TO_B * dcb) >>> 8);
		return c;
	endfunction

	function automatic int weigh_channel(input logic [7:0] ca, input logic [7:0] cb,
			input int wa);
		return int'(clip_byte((int'(ca) * wa + int'(cb) * (256 - wa)) >>> 8));
	endfunction

	function automatic pix_t blend_pixel(input pair_t p, input logic [7:0] w);
		rgb_t pa;
		rgb_t pb;
		int   wa;
		int   r;
		int   g;
		int   b;
		pix_t o;
		wa = int'(w);
		pa = ycc_to_rgb(p.luma_a, p.cb_a, p.cr_a);
		pb = ycc_to_rgb(p.luma_b, p.cb_b, p.cr_b);
		r  = weigh_channel(pa.r, pb.r, wa);
		g  = weigh_channel(pa.g, pb.g, wa);
		b  = weigh_channel(pa.b, pb.b, wa);
		o.luma_out = clip_byte((Y_FROM_R * r + Y_FROM_G * g + Y_FROM_B * b) >>> 8);
		o.cb_out   = clip_byte(((-CB_FROM_R * r - CB_FROM_G * g + CB_FROM_B * b) >>> 8)
			+ CHROMA_MID);
		o.cr_out   = clip_byte(((CR_FROM_R * r - CR_FROM_G * g - CR_FROM_B * b) >>> 8)
			+ CHROMA_MID);
		return o;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_pixels.delete();
			weight = WEIGHT_RESET;
			pixels_owed <= 0;
		end else begin
			if (pixels.valid && pixels.ready) begin
				if (owed_pixels.size() == 0) begin
					$error("blended pixel with none expected: luma_out %0d cb_out %0d cr_out %0d",
						pixels.data.luma_out, pixels.data.cb_out, pixels.data.cr_out);
					fail_count++;
				end else begin
					want_pix = owed_pixels.pop_front();
					check_field("luma_out", want_pix.luma_out, pixels.data.luma_out);
					check_field("cb_out", want_pix.cb_out, pixels.data.cb_out);
					check_field("cr_out", want_pix.cr_out, pixels.data.cr_out);
				end
			end
			if (pairs.valid && pairs.ready) begin
				owed_pixels.push_back(blend_pixel(pairs.data, weight));
			end
			if (cfg.valid && cfg.ready) begin
				weight = cfg.data;
			end
			pixels_owed <= owed_pixels.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the YCbCr alpha blender bench: clock, reset, pixel-pair and weight stimulus,
// output back-pressure and the verdict. Depends on ypab_pkg, the channel interfaces,
// yuv_pixel_alpha_blend and ypab_blend_checker.
module tb_top;
	import ypab_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 12;

	logic clk;
	logic arst_n;

	ypab_pair_if in_ch();
	ypab_pix_if  out_ch();
	ypab_cfg_if  cfg_ch();

	int fail_count;
	int pixels_owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;

	pair_t corner_pairs[10] = '{
		48'h00_00_00_00_00_00,
		48'hFF_FF_FF_FF_FF_FF,
		48'hFF_80_80_00_80_80,
		48'h00_80_80_FF_80_80,
		48'h80_00_FF_80_FF_00,
		48'h80_FF_00_80_00_FF,
		48'hAA_AA_AA_55_55_55,
		48'h55_55_55_AA_AA_AA,
		48'hFF_00_00_00_FF_FF,
		48'h10_80_80_EB_80_80
	};

	yuv_pixel_alpha_blend uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (in_ch),
		.pix_out (out_ch),
		.cfg     (cfg_ch)
	);

	ypab_blend_checker blend_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pairs       (in_ch),
		.pixels      (out_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.pixels_owed (pixels_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// output back-pressure; a requested hold-off keeps ready low for a long stretch
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = HOLD_CYCLES;
			hold_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [7:0] corner_byte(input logic [7:0] v);
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd128;
			default: return v;
		endcase
	endfunction

	// mostly moderate chroma so the blend is exercised in gamut; the rest is raw or extreme
	function automatic pair_t random_pair();
		logic [63:0] bits;
		int          style;
		pair_t       p;
		bits  = {$urandom, $urandom};
		p     = bits[47:0];
		style = $urandom_range(99);
		if (style < 60) begin
			p.cb_a = 8'($urandom_range(168, 88));
			p.cr_a = 8'($urandom_range(168, 88));
			p.cb_b = 8'($urandom_range(168, 88));
			p.cr_b = 8'($urandom_range(168, 88));
		end else if (style < 75) begin
			p.luma_a = corner_byte(p.luma_a);
			p.cb_a   = corner_byte(p.cb_a);
			p.cr_a   = corner_byte(p.cr_a);
			p.luma_b = corner_byte(p.luma_b);
			p.cb_b   = corner_byte(p.cb_b);
			p.cr_b   = corner_byte(p.cr_b);
		end
		return p;
	endfunction

	// enter after any edge; return at the edge where the beat is taken
	task automatic send_pair(input pair_t p);
		@(negedge clk);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= p;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_pair(random_pair());
		end
	endtask

	// drop valid, then hold until every owed pixel has come out
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pixels_owed != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// enter at a falling edge with the block idle
	task automatic write_weight(input logic [7:0] w);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners under the reset weight, then with the second pixel alone
		foreach (corner_pairs[k]) send_pair(corner_pairs[k]);
		drain();
		write_weight(8'd0);
		foreach (corner_pairs[k]) send_pair(corner_pairs[k]);
		drain();

		write_weight(8'd128);
		send_random(120);
		hold_requests++;
		send_random(130);
		drain();

		write_weight(8'd1);
		idle_pct = 79;
		send_random(250);
		drain();

		write_weight(8'($urandom_range(254, 2)));
		idle_pct  = 0;
		stall_pct = 79;
		send_random(250);
		drain();

		write_weight(8'd200);
		idle_pct  = 6;
		stall_pct = 6;
		send_random(250);
		drain();

		write_weight(8'd255);
		idle_pct  = 79;
		stall_pct = 79;
		send_random(150);
		drain();

		write_weight(8'd0);
		idle_pct  = 0;
		stall_pct = 0;
		send_random(100);
		drain();
		send_random(100);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
